FILE: rtl/vsp_pkg.sv
// Shared constants, payload structs and command codes for the varispeed sample player.
// Used by every module under rtl/ except vsp_ram; depends on nothing else.
`timescale 1ns / 1ps

package vsp_pkg;

	// Sample memory geometry and playhead format.
	localparam int ADDR_BITS    = 16;
	localparam int MAX_CHANNELS = 2;
	localparam int SAMPLE_BITS  = 16;
	localparam int FRAC_BITS    = 16;
	localparam int CH_BITS      = 1;
	localparam int MEM_DEPTH    = MAX_CHANNELS * (2 ** ADDR_BITS);
	localparam int MEM_AW       = $clog2(MEM_DEPTH);

	// Register widths.
	localparam int PT_BITS       = 17;
	localparam int STEP_BITS     = 24;
	localparam int CNT_BITS      = 2;
	localparam int GAIN_BITS     = 15;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 24;

	// The playhead's integer part has the region bound width, one bit above the address width.
	localparam int POS_BITS = PT_BITS + FRAC_BITS;

	// Gain scaling: unsigned Q1.14 with round-half-up and saturation.
	localparam int GAIN_MAX    = 20626;
	localparam int GAIN_SHIFT  = 14;
	localparam int ROUND_BIAS  = 8192;
	localparam int PROD_BITS   = 2 * SAMPLE_BITS;
	localparam int SCALED_BITS = PROD_BITS + 1 - GAIN_SHIFT;

	// Queue depths (powers of two).
	localparam int TQ_DEPTH = 2;
	localparam int TQ_AW    = $clog2(TQ_DEPTH);
	localparam int TQ_CW    = $clog2(TQ_DEPTH + 1);
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	// Register reset values.
	localparam logic [PT_BITS-1:0]   START_RST = '0;
	localparam logic [PT_BITS-1:0]   END_RST   = PT_BITS'(65536);
	localparam logic [PT_BITS-1:0]   LEN_RST   = '0;
	localparam logic [CNT_BITS-1:0]  CHCNT_RST = CNT_BITS'(1);
	localparam logic [STEP_BITS-1:0] STEP_RST  = STEP_BITS'(65536);
	localparam logic [GAIN_BITS-1:0] GAIN_RST  = GAIN_BITS'(16384);

	typedef enum logic [2:0] {
		CMD_WRITE = 3'd0,
		CMD_TICK  = 3'd1,
		CMD_PLAY  = 3'd2,
		CMD_PAUSE = 3'd3,
		CMD_STOP  = 3'd4,
		CMD_SEEK  = 3'd5
	} cmd_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_START   = 3'd0,
		REG_END     = 3'd1,
		REG_LENGTH  = 3'd2,
		REG_CHANNEL = 3'd3,
		REG_STEP    = 3'd4,
		REG_REVERSE = 3'd5,
		REG_LOOP    = 3'd6,
		REG_GAIN    = 3'd7
	} cfg_reg_t;

	// Work classes handed from the front to the back.
	typedef enum logic [1:0] {
		TASK_WRITE  = 2'd0,
		TASK_RENDER = 2'd1,
		TASK_NOROOM = 2'd2
	} task_kind_t;

	typedef struct packed {
		logic [2:0]        cmd;
		logic              write_channel;
		logic [15:0]       write_address;
		logic signed [15:0] write_value;
		logic [15:0]       seek_position;
	} in_item_t;

	typedef struct packed {
		logic              out_channel;
		logic signed [15:0] out_value;
		logic              last_of_frame;
		logic              finished_event;
		logic              still_playing;
	} out_item_t;

	typedef struct packed {
		task_kind_t            kind;
		logic [CH_BITS-1:0]    channel;
		logic [ADDR_BITS-1:0]  address;
		logic [SAMPLE_BITS-1:0] value;
		logic [CNT_BITS-1:0]   chans;
		logic                  fin;
		logic                  playing;
	} task_t;

endpackage

FILE: rtl/vsp_ram.sv
// Generic single-port RAM with registered read data.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

module vsp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One access per cycle: the addressed word is read into the output register, and written as well when we is high.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

FILE: rtl/vsp_front.sv
// Front end: configuration registers, transport state and the playhead.
// Classifies accepted sample writes, and ticks while playing, into back-end tasks. Depends on vsp_pkg.
`timescale 1ns / 1ps

module vsp_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	input  vsp_pkg::in_item_t                  in_item,
	output logic                               full,
	input  logic                               cfg_write,
	input  logic [vsp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [vsp_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                               tq_full,
	output logic                               tq_push,
	output vsp_pkg::task_t                     tq_data,
	output logic [vsp_pkg::GAIN_BITS-1:0]      gain
);

	localparam logic [vsp_pkg::FRAC_BITS-1:0] FRAC_ZERO = '0;

	logic [vsp_pkg::PT_BITS-1:0]   start_q, end_q, len_q;
	logic [vsp_pkg::CNT_BITS-1:0]  chcnt_q;
	logic [vsp_pkg::STEP_BITS-1:0] step_q;
	logic                          rev_q, loop_q;
	logic [vsp_pkg::GAIN_BITS-1:0] gain_q;
	logic [vsp_pkg::POS_BITS-1:0]  pos_q, pos_d;
	logic                          play_q, play_d;

	logic                          accept;
	logic [vsp_pkg::POS_BITS:0]    adv;
	logic [vsp_pkg::POS_BITS-1:0]  new_pos, rp_cur;
	logic                          room, fin_adv, tick_fin, seek_out;
	logic [vsp_pkg::CNT_BITS-1:0]  chans;

	function automatic logic [vsp_pkg::POS_BITS-1:0] reset_point(
		input logic                        rev,
		input logic [vsp_pkg::PT_BITS-1:0] st,
		input logic [vsp_pkg::PT_BITS-1:0] en
	);
		logic [vsp_pkg::PT_BITS-1:0] last_idx;
		last_idx = en - vsp_pkg::PT_BITS'(1);
		if (!rev) begin
			return {st, FRAC_ZERO};
		end else if (en == '0) begin
			return '0;
		end else begin
			return {last_idx, FRAC_ZERO};
		end
	endfunction

	assign accept = push && !tq_full;
	assign full   = tq_full;
	assign rp_cur = reset_point(rev_q, start_q, end_q);

	// Clamp gain for the multiplier in the back end.
	assign gain = (gain_q > vsp_pkg::GAIN_BITS'(vsp_pkg::GAIN_MAX)) ?
		vsp_pkg::GAIN_BITS'(vsp_pkg::GAIN_MAX) : gain_q;

	// Effective channel count.
	always_comb begin
		if (chcnt_q == '0) begin
			chans = vsp_pkg::CNT_BITS'(1);
		end else if (chcnt_q > vsp_pkg::CNT_BITS'(vsp_pkg::MAX_CHANNELS)) begin
			chans = vsp_pkg::CNT_BITS'(vsp_pkg::MAX_CHANNELS);
		end else begin
			chans = chcnt_q;
		end
	end

	// Playhead advance, room check and end check share one adder; the seek range check is also here.
	always_comb begin
		if (rev_q) begin
			adv = {1'b0, pos_q} - (vsp_pkg::POS_BITS + 1)'(step_q);
		end else begin
			adv = {1'b0, pos_q} + (vsp_pkg::POS_BITS + 1)'(step_q);
		end
		new_pos = adv[vsp_pkg::POS_BITS-1:0];
		if (step_q == '0) begin
			room = 1'b1;
		end else if (rev_q) begin
			room = !adv[vsp_pkg::POS_BITS];
		end else begin
			room = adv <= {1'b0, len_q, FRAC_ZERO};
		end
		if (rev_q) begin
			fin_adv = new_pos <= {start_q, FRAC_ZERO};
		end else begin
			fin_adv = new_pos >= {end_q, FRAC_ZERO};
		end
		tick_fin = !room || fin_adv;
		seek_out = ({1'b0, in_item.seek_position} > end_q) ||
			({1'b0, in_item.seek_position} < start_q);
	end

	// Transport update and task generation.
	always_comb begin
		pos_d           = pos_q;
		play_d          = play_q;
		tq_push         = 1'b0;
		tq_data.kind    = vsp_pkg::TASK_WRITE;
		tq_data.channel = in_item.write_channel;
		tq_data.address = in_item.write_address;
		tq_data.value   = in_item.write_value;
		tq_data.chans   = chans;
		tq_data.fin     = 1'b0;
		tq_data.playing = 1'b0;
		if (accept) begin
			case (in_item.cmd)
				vsp_pkg::CMD_WRITE: begin
					tq_push = int'(in_item.write_channel) < vsp_pkg::MAX_CHANNELS;
				end
				vsp_pkg::CMD_TICK: begin
					if (play_q) begin
						tq_push = 1'b1;
						if (tick_fin) begin
							play_d = loop_q;
							pos_d  = rp_cur;
						end else begin
							pos_d = new_pos;
						end
						tq_data.kind    = room ? vsp_pkg::TASK_RENDER : vsp_pkg::TASK_NOROOM;
						tq_data.address = pos_q[vsp_pkg::FRAC_BITS +: vsp_pkg::ADDR_BITS];
						tq_data.fin     = tick_fin;
						tq_data.playing = play_d;
					end
				end
				vsp_pkg::CMD_PLAY: begin
					if (len_q != '0) begin
						play_d = 1'b1;
					end
				end
				vsp_pkg::CMD_PAUSE: begin
					play_d = 1'b0;
				end
				vsp_pkg::CMD_STOP: begin
					play_d = 1'b0;
					pos_d  = rp_cur;
				end
				vsp_pkg::CMD_SEEK: begin
					if (seek_out) begin
						play_d = play_q && loop_q;
						pos_d  = rp_cur;
					end else begin
						pos_d = vsp_pkg::POS_BITS'({in_item.seek_position, FRAC_ZERO});
					end
				end
				default: begin
				end
			endcase
		end
		// A reverse-register write while not playing moves the playhead to the written direction's reset point.
		if (cfg_write && cfg_index == vsp_pkg::REG_REVERSE && !play_q) begin
			pos_d = reset_point(cfg_data[0], start_q, end_q);
		end
	end

	// Transport state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= {vsp_pkg::START_RST, FRAC_ZERO};
			play_q <= 1'b0;
		end else begin
			pos_q  <= pos_d;
			play_q <= play_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= vsp_pkg::START_RST;
			end_q   <= vsp_pkg::END_RST;
			len_q   <= vsp_pkg::LEN_RST;
			chcnt_q <= vsp_pkg::CHCNT_RST;
			step_q  <= vsp_pkg::STEP_RST;
			rev_q   <= 1'b0;
			loop_q  <= 1'b0;
			gain_q  <= vsp_pkg::GAIN_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				vsp_pkg::REG_START:   start_q <= cfg_data[vsp_pkg::PT_BITS-1:0];
				vsp_pkg::REG_END:     end_q   <= cfg_data[vsp_pkg::PT_BITS-1:0];
				vsp_pkg::REG_LENGTH:  len_q   <= cfg_data[vsp_pkg::PT_BITS-1:0];
				vsp_pkg::REG_CHANNEL: chcnt_q <= cfg_data[vsp_pkg::CNT_BITS-1:0];
				vsp_pkg::REG_STEP:    step_q  <= cfg_data[vsp_pkg::STEP_BITS-1:0];
				vsp_pkg::REG_REVERSE: rev_q   <= cfg_data[0];
				vsp_pkg::REG_LOOP:    loop_q  <= cfg_data[0];
				vsp_pkg::REG_GAIN:    gain_q  <= cfg_data[vsp_pkg::GAIN_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: rtl/vsp_task_q.sv
// Short task queue between the front end and the back end.
// Show-ahead FIFO of vsp_pkg::task_t entries. Depends on vsp_pkg.
`timescale 1ns / 1ps

module vsp_task_q (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  vsp_pkg::task_t data_in,
	output logic           full,
	input  logic           pop,
	output vsp_pkg::task_t head,
	output logic           empty
);

	vsp_pkg::task_t               mem_q [vsp_pkg::TQ_DEPTH];
	logic [vsp_pkg::TQ_AW-1:0]    wr_q, rd_q;
	logic [vsp_pkg::TQ_CW-1:0]    count_q;
	logic                         do_push, do_pop;

	assign full    = count_q == vsp_pkg::TQ_CW'(vsp_pkg::TQ_DEPTH);
	assign empty   = count_q == '0;
	assign head    = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= data_in;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + vsp_pkg::TQ_AW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + vsp_pkg::TQ_AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + vsp_pkg::TQ_CW'(1);
			end else if (!do_push && do_pop) begin
				count_q <= count_q - vsp_pkg::TQ_CW'(1);
			end
		end
	end

endmodule

FILE: rtl/vsp_back.sv
// Back end: sample memory access, gain multiply, rounding and saturation,
// and the result queue. Depends on vsp_pkg and vsp_ram.
`timescale 1ns / 1ps

module vsp_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  vsp_pkg::task_t                task_head,
	input  logic                          task_empty,
	output logic                          task_pop,
	input  logic [vsp_pkg::GAIN_BITS-1:0] gain,
	output logic                          empty,
	input  logic                          pop,
	output vsp_pkg::out_item_t            out_item
);

	typedef struct packed {
		logic channel;
		logic last;
		logic fin;
		logic playing;
		logic zero;
	} meta_t;

	logic [vsp_pkg::CNT_BITS-1:0]       k_q;
	logic                               is_last, can_issue, issue;
	logic [vsp_pkg::OQ_CW:0]            in_flight;
	logic                               ram_we;
	logic [vsp_pkg::MEM_AW-1:0]         ram_addr;
	logic [vsp_pkg::SAMPLE_BITS-1:0]    ram_rdata;
	meta_t                              meta_c;
	logic                               v_s1, v_s2;
	meta_t                              meta_s1, meta_s2;
	logic signed [vsp_pkg::PROD_BITS-1:0] mult_c;
	logic signed [vsp_pkg::PROD_BITS-1:0] prod_c, prod_s2;
	logic [vsp_pkg::PROD_BITS:0]        biased;
	logic [vsp_pkg::SCALED_BITS-1:0]    scaled;
	logic [vsp_pkg::SAMPLE_BITS-1:0]    sat;
	logic [vsp_pkg::SCALED_BITS-vsp_pkg::SAMPLE_BITS:0] top_bits;
	vsp_pkg::out_item_t                 res;
	vsp_pkg::out_item_t                 oq_q [vsp_pkg::OQ_DEPTH];
	logic [vsp_pkg::OQ_AW-1:0]          oq_wr_q, oq_rd_q;
	logic [vsp_pkg::OQ_CW-1:0]          oq_count_q;
	logic                               oq_pop;

	// Issue only when the result queue has room for everything in flight.
	assign in_flight = (vsp_pkg::OQ_CW + 1)'(oq_count_q) +
		(vsp_pkg::OQ_CW + 1)'(v_s1) + (vsp_pkg::OQ_CW + 1)'(v_s2);
	assign can_issue = in_flight < (vsp_pkg::OQ_CW + 1)'(vsp_pkg::OQ_DEPTH);
	assign is_last   = (k_q + vsp_pkg::CNT_BITS'(1)) == task_head.chans;

	// Task dispatch: a write goes to memory; a render issues per channel.
	always_comb begin
		ram_we   = 1'b0;
		issue    = 1'b0;
		task_pop = 1'b0;
		ram_addr = (vsp_pkg::MEM_AW'(task_head.channel) << vsp_pkg::ADDR_BITS) |
			vsp_pkg::MEM_AW'(task_head.address);
		meta_c.channel = k_q[0];
		meta_c.last    = is_last;
		meta_c.fin     = task_head.fin;
		meta_c.playing = task_head.playing;
		meta_c.zero    = 1'b0;
		if (!task_empty) begin
			case (task_head.kind)
				vsp_pkg::TASK_WRITE: begin
					ram_we   = 1'b1;
					task_pop = 1'b1;
				end
				vsp_pkg::TASK_RENDER: begin
					ram_addr = (vsp_pkg::MEM_AW'(k_q[vsp_pkg::CH_BITS-1:0]) <<
						vsp_pkg::ADDR_BITS) | vsp_pkg::MEM_AW'(task_head.address);
					issue    = can_issue;
					task_pop = can_issue && is_last;
				end
				vsp_pkg::TASK_NOROOM: begin
					meta_c.channel = 1'b0;
					meta_c.last    = 1'b1;
					meta_c.zero    = 1'b1;
					issue          = can_issue;
					task_pop       = can_issue;
				end
				default: begin
					task_pop = 1'b1;
				end
			endcase
		end
	end

	// Channel counter within a render task.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (issue && task_head.kind == vsp_pkg::TASK_RENDER) begin
			k_q <= is_last ? '0 : k_q + vsp_pkg::CNT_BITS'(1);
		end
	end

	vsp_ram #(
		.WIDTH(vsp_pkg::SAMPLE_BITS),
		.DEPTH(vsp_pkg::MEM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(task_head.value),
		.rdata(ram_rdata)
	);

	// Gain multiply on the registered sample; a tick with no room renders zero.
	assign mult_c = $signed(ram_rdata) * $signed({1'b0, gain});
	assign prod_c = meta_s1.zero ? '0 : mult_c;

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		meta_s1 <= meta_c;
		meta_s2 <= meta_s1;
		prod_s2 <= prod_c;
	end

	// Round half up, floor shift, saturate to the sample width.
	always_comb begin
		biased   = {prod_s2[vsp_pkg::PROD_BITS-1], prod_s2} +
			(vsp_pkg::PROD_BITS + 1)'(vsp_pkg::ROUND_BIAS);
		scaled   = biased[vsp_pkg::PROD_BITS:vsp_pkg::GAIN_SHIFT];
		top_bits = scaled[vsp_pkg::SCALED_BITS-1:vsp_pkg::SAMPLE_BITS-1];
		if (top_bits == '0 || top_bits == '1) begin
			sat = scaled[vsp_pkg::SAMPLE_BITS-1:0];
		end else if (scaled[vsp_pkg::SCALED_BITS-1]) begin
			sat = {1'b1, {(vsp_pkg::SAMPLE_BITS - 1){1'b0}}};
		end else begin
			sat = {1'b0, {(vsp_pkg::SAMPLE_BITS - 1){1'b1}}};
		end
		res.out_channel    = meta_s2.channel;
		res.out_value      = sat;
		res.last_of_frame  = meta_s2.last;
		res.finished_event = meta_s2.fin;
		res.still_playing  = meta_s2.playing;
	end

	// Result queue.
	assign empty    = oq_count_q == '0;
	assign oq_pop   = pop && !empty;
	assign out_item = oq_q[oq_rd_q];

	always_ff @(posedge clk) begin
		if (v_s2) begin
			oq_q[oq_wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q    <= '0;
			oq_rd_q    <= '0;
			oq_count_q <= '0;
		end else begin
			if (v_s2) begin
				oq_wr_q <= oq_wr_q + vsp_pkg::OQ_AW'(1);
			end
			if (oq_pop) begin
				oq_rd_q <= oq_rd_q + vsp_pkg::OQ_AW'(1);
			end
			if (v_s2 && !oq_pop) begin
				oq_count_q <= oq_count_q + vsp_pkg::OQ_CW'(1);
			end else if (!v_s2 && oq_pop) begin
				oq_count_q <= oq_count_q - vsp_pkg::OQ_CW'(1);
			end
		end
	end

endmodule

FILE: rtl/varispeed_sample_player_unit.sv
// Varispeed sample player: one playback voice with a fractional playhead.
// Path: a tick's results pass through the task queue, then the sample read, multiply,
// and round and saturate steps into the result queue.
// Throughput: one item per cycle for control and sample writes while the task queue
// has room; a tick holds the single-port sample memory for one read per channel.
// Reset clears transport and registers to defaults; sample memory is undefined
// until written and has no clearing pass.
`timescale 1ns / 1ps

module varispeed_sample_player_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  vsp_pkg::in_item_t                 in_item,
	output logic                              full,
	output logic                              empty,
	input  logic                              pop,
	output vsp_pkg::out_item_t                out_item,
	input  logic                              cfg_write,
	input  logic [vsp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [vsp_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	logic                          tq_push, tq_full, tq_pop, tq_empty;
	vsp_pkg::task_t                tq_data, tq_head;
	logic [vsp_pkg::GAIN_BITS-1:0] gain;

	// Transport and classification.
	vsp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.in_item  (in_item),
		.full     (full),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.tq_full  (tq_full),
		.tq_push  (tq_push),
		.tq_data  (tq_data),
		.gain     (gain)
	);

	// Decoupling queue.
	vsp_task_q u_task_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (tq_push),
		.data_in(tq_data),
		.full   (tq_full),
		.pop    (tq_pop),
		.head   (tq_head),
		.empty  (tq_empty)
	);

	// Memory access, rendering and result queue.
	vsp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.task_head (tq_head),
		.task_empty(tq_empty),
		.task_pop  (tq_pop),
		.gain      (gain),
		.empty     (empty),
		.pop       (pop),
		.out_item  (out_item)
	);

endmodule
